### hw/rtl/arx_plant_simulator_top_defines.svh
// Assertion macros shared by the ARX plant simulator RTL.
`ifndef ARX_PLANT_SIMULATOR_TOP_DEFINES_SVH
`define ARX_PLANT_SIMULATOR_TOP_DEFINES_SVH

// Implication checked in the same cycle.
`define ARX_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define ARX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/arx_pkg.sv
// Shared types and constants of the ARX plant simulator.
package arx_pkg;

   localparam int CFG_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int MODE_W   = 2;
   localparam int TAP_W    = 3;
   localparam int COEF_W   = 18;
   localparam int SAMPLE_W = 16;
   localparam int NOISE_W  = 15;
   localparam int STATUS_W = 2;
   localparam int PROD_W   = COEF_W + SAMPLE_W;
   localparam int FACT_W   = 23;
   localparam int DEN_W    = FACT_W + COEF_W;
   localparam int QUOT_W   = 17;

   localparam logic [FACT_W-1:0] NOISE_BASE = 23'd6520633;
   localparam logic [FACT_W-1:0] NOISE_DEN  = 23'd6553400;

   localparam logic [QUOT_W-1:0] Q_POS_LIM = 17'd32767;
   localparam logic [QUOT_W-1:0] Q_NEG_LIM = 17'd32768;
   localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B_TAPS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_A_TAPS      = 2'd2;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_WR_B   = 2'd1,
      MODE_WR_A   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_SAT     = 2'd1,
      STAT_A0_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_B,
      KIND_A,
      KIND_A0
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_ABS,
      S_MUL_LO,
      S_MUL_HI,
      S_PREP,
      S_START,
      S_DIV,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_CHECK,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

endpackage

### hw/rtl/arx_div.sv
// Serial restoring divider giving a short quotient and an overflow flag.
module arx_div #(
   parameter int N_W = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [N_W-1:0]      num,
   input  logic [N_W-1:0]      dvs,
   output arx_pkg::div_res_type res
);
   import arx_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   div_state_type     state_ff, state_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [N_W-1:0]    dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ge;

   assign ge = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               rem_in   = num;
               dsh_in   = dvs << QUOT_W;
               quot_in  = '0;
               ovf_in   = 1'b0;
               state_in = DIV_CHECK;
            end
         end
         DIV_CHECK: begin
            // A quotient that needs more bits than we keep is flagged at once.
            if (ge) begin
               ovf_in   = 1'b1;
               state_in = DIV_DONE;
            end else begin
               dsh_in   = dsh_ff >> 1;
               cnt_in   = CNT_W'(QUOT_W - 1);
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            dsh_in  = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = DIV_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         DIV_DONE: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign res = '{done: (state_ff == DIV_DONE), ovf: ovf_ff, quot: quot_ff};

endmodule

### hw/rtl/arx_plant_simulator_top.sv
// Top level of the ARX plant simulator: control, memories and multiply-accumulate.
// One item is taken at a time. A sample item is accepted in the idle state, streams the
// coefficient and history memories (one read port each) through the multiply-accumulate
// pipeline and lets it drain, passes the sign, noise and scale multiplies and divider
// set-up (S_ABS, S_MUL_LO, S_MUL_HI, S_PREP, S_START), runs the serial divider, which
// yields one quotient bit per cycle, and loads the result in S_FIN once the result
// register is free. Coefficient writes and history clears go from the idle state straight
// to S_FIN. Histories are cleared at once through per-entry valid bits, so there is no
// clearing pass after reset. The result register lets a finished result wait while the
// next item is accepted.
`include "arx_plant_simulator_top_defines.svh"

module arx_plant_simulator_top #(
   parameter int MAX_B_TAPS = 8,
   parameter int MAX_A_TAPS = 8,
   parameter int MAX_DELAY  = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_tap_index,
   input  logic signed [17:0] req_coef_value,
   input  logic signed [15:0] req_sample_in,
   input  logic [14:0] req_noise_raw,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_y_out,
   output logic        rsp_sample_done,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   import arx_pkg::*;

   localparam int UD  = MAX_B_TAPS + MAX_DELAY;
   localparam int YD  = MAX_A_TAPS;
   localparam int HD  = UD + YD;
   localparam int CD  = MAX_B_TAPS + MAX_A_TAPS;
   localparam int UAW = (UD > 1) ? $clog2(UD) : 1;
   localparam int YAW = (YD > 1) ? $clog2(YD) : 1;
   localparam int HAW = $clog2(HD);
   localparam int CAW = $clog2(CD);
   localparam int CNT_RAW = $clog2(HD + CD + 1) + 1;
   localparam int CNT_W = (CNT_RAW > 5) ? CNT_RAW : 5;
   localparam int ACC_W = PROD_W + $clog2(CD);
   localparam int LO_W  = ACC_W / 2;
   localparam int HI_W  = ACC_W - LO_W;
   localparam int N_W   = ACC_W + FACT_W + 2;

   // Configuration registers.
   logic [CFG_W-1:0] delay_ff, btaps_ff, ataps_ff;

   // Control and item registers.
   state_type            state_ff, state_in;
   logic                 is_sample_ff, is_sample_in;
   logic [NOISE_W-1:0]   noise_ff, noise_in;
   logic [UAW-1:0]       u_wp_ff, u_wp_in, u_next;
   logic [YAW-1:0]       y_wp_ff, y_wp_in, y_next;

   // Memories with per-entry valid bits.
   logic [SAMPLE_W-1:0]        hist_mem [HD];
   logic [HD-1:0]              hist_vld_ff;
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic                       hist_rdv_ff;
   logic                       hist_we, hist_clr;
   logic [HAW-1:0]             hist_waddr, hist_raddr;
   logic [SAMPLE_W-1:0]        hist_wdata;
   logic [COEF_W-1:0]          coef_mem [CD];
   logic [CD-1:0]              coef_vld_ff;
   logic signed [COEF_W-1:0]   coef_rd_ff;
   logic                       coef_rdv_ff;
   logic                       coef_we;
   logic [CAW-1:0]             coef_waddr, coef_raddr;
   logic [COEF_W-1:0]          coef_wdata;

   // Accumulate pipeline.
   logic                     iss_ff, iss_in;
   logic [CNT_W-1:0]         term_ff, term_in;
   logic                     rd_vld_ff;
   kind_type                 rd_kind_ff, kind_c;
   logic                     mul_vld_ff, mul_sub_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [COEF_W-1:0] a0_ff;
   logic signed [COEF_W-1:0] coef_val;
   logic signed [SAMPLE_W-1:0] hist_val;

   logic [CNT_W-1:0] k_x, k_eff, nb_x, nb, na_x, na, last_term;
   logic [CNT_W-1:0] u_off, y_off, u_wp_x, y_wp_x, ua_c, ya_c;

   // Scaling and division.
   logic                      neg_ff, neg_in;
   logic [ACC_W-1:0]          mag_ff, mag_in;
   logic [COEF_W-1:0]         a0mag_ff, a0mag_in;
   logic [FACT_W-1:0]         fact_ff, fact_in;
   logic [LO_W+FACT_W-1:0]    pp_lo_ff, pp_lo_in;
   logic [HI_W+FACT_W-1:0]    pp_hi_ff, pp_hi_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [N_W-1:0]            num_ff, num_in, dvs_ff, dvs_in;
   logic                      div_start;
   div_res_type               div_res;
   logic [SAMPLE_W-1:0]       y_ff, y_in;
   status_type                stat_ff, stat_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_y_ff, rsp_y_in;
   logic                rsp_done_ff, rsp_done_in;
   status_type          rsp_status_ff, rsp_status_in;

   arx_div #(
      .N_W(N_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (num_ff),
      .dvs  (dvs_ff),
      .res  (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= CFG_W'(0);
         btaps_ff <= CFG_W'(1);
         ataps_ff <= CFG_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INPUT_DELAY: delay_ff <= csr_wdata;
            CSR_B_TAPS:      btaps_ff <= csr_wdata;
            CSR_A_TAPS:      ataps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // History memory: input samples in the lower region, outputs above it.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff  <= hist_mem[hist_raddr];
      hist_rdv_ff <= hist_vld_ff[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || hist_clr) begin
         hist_vld_ff <= '0;
      end else if (hist_we) begin
         hist_vld_ff[hist_waddr] <= 1'b1;
      end
   end

   // Coefficient memory: B taps first, then A taps.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff  <= coef_mem[coef_raddr];
      coef_rdv_ff <= coef_vld_ff[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_we) begin
         coef_vld_ff[coef_waddr] <= 1'b1;
      end
   end

   assign coef_val = coef_rdv_ff ? coef_rd_ff : '0;
   assign hist_val = hist_rdv_ff ? hist_rd_ff : '0;

   // Effective register values.
   always_comb begin
      k_x   = CNT_W'(delay_ff);
      k_eff = (k_x > CNT_W'(MAX_DELAY)) ? CNT_W'(MAX_DELAY) : k_x;
      nb_x  = CNT_W'(btaps_ff);
      if (nb_x == '0) begin
         nb = CNT_W'(1);
      end else if (nb_x > CNT_W'(MAX_B_TAPS)) begin
         nb = CNT_W'(MAX_B_TAPS);
      end else begin
         nb = nb_x;
      end
      na_x = CNT_W'(ataps_ff);
      if (na_x == '0) begin
         na = CNT_W'(1);
      end else if (na_x > CNT_W'(MAX_A_TAPS)) begin
         na = CNT_W'(MAX_A_TAPS);
      end else begin
         na = na_x;
      end
      last_term = nb + na - 1'b1;
   end

   // Term addressing: B terms, then A terms from A1 on, and A0 read last.
   always_comb begin
      u_off  = k_eff + term_ff;
      y_off  = term_ff - nb;
      u_wp_x = CNT_W'(u_wp_ff);
      y_wp_x = CNT_W'(y_wp_ff);
      ua_c   = (u_wp_x >= u_off) ? (u_wp_x - u_off) : (u_wp_x + CNT_W'(UD) - u_off);
      ya_c   = (y_wp_x >= y_off) ? (y_wp_x - y_off) : (y_wp_x + CNT_W'(YD) - y_off);
      if (term_ff < nb) begin
         kind_c     = KIND_B;
         hist_raddr = HAW'(ua_c);
         coef_raddr = CAW'(term_ff);
      end else if (term_ff == last_term) begin
         kind_c     = KIND_A0;
         hist_raddr = HAW'(CNT_W'(UD) + ya_c);
         coef_raddr = CAW'(MAX_B_TAPS);
      end else begin
         kind_c     = KIND_A;
         hist_raddr = HAW'(CNT_W'(UD) + ya_c);
         coef_raddr = CAW'(CNT_W'(MAX_B_TAPS) + y_off + 1'b1);
      end
   end

   assign u_next = (u_wp_ff == UAW'(UD - 1)) ? '0 : (u_wp_ff + 1'b1);
   assign y_next = (y_wp_ff == YAW'(YD - 1)) ? '0 : (y_wp_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         mul_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         u_wp_ff      <= '0;
         y_wp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= iss_ff;
         mul_vld_ff   <= rd_vld_ff && (rd_kind_ff != KIND_A0);
         rsp_valid_ff <= rsp_valid_in;
         u_wp_ff      <= u_wp_in;
         y_wp_ff      <= y_wp_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff      <= term_in;
      rd_kind_ff   <= kind_c;
      prod_ff      <= coef_val * hist_val;
      mul_sub_ff   <= (rd_kind_ff == KIND_A);
      if (rd_vld_ff && (rd_kind_ff == KIND_A0)) begin
         a0_ff <= coef_val;
      end
      acc_ff       <= acc_in;
      is_sample_ff <= is_sample_in;
      noise_ff     <= noise_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      a0mag_ff     <= a0mag_in;
      fact_ff      <= fact_in;
      pp_lo_ff     <= pp_lo_in;
      pp_hi_ff     <= pp_hi_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      dvs_ff       <= dvs_in;
      y_ff         <= y_in;
      stat_ff      <= stat_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      is_sample_in  = is_sample_ff;
      noise_in      = noise_ff;
      u_wp_in       = u_wp_ff;
      y_wp_in       = y_wp_ff;
      iss_in        = iss_ff && (term_ff != last_term);
      term_in       = term_ff + 1'b1;
      acc_in        = acc_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      a0mag_in      = a0mag_ff;
      fact_in       = fact_ff;
      pp_lo_in      = pp_lo_ff;
      pp_hi_in      = pp_hi_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      dvs_in        = dvs_ff;
      y_in          = y_ff;
      stat_in       = stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_y_in      = rsp_y_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_status_in = rsp_status_ff;
      hist_we       = 1'b0;
      hist_clr      = 1'b0;
      hist_waddr    = HAW'(u_next);
      hist_wdata    = req_sample_in;
      coef_we       = 1'b0;
      coef_waddr    = CAW'(req_tap_index);
      coef_wdata    = req_coef_value;
      div_start     = 1'b0;

      if (mul_vld_ff) begin
         acc_in = mul_sub_ff ? (acc_ff - ACC_W'(prod_ff)) : (acc_ff + ACC_W'(prod_ff));
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               noise_in     = req_noise_raw;
               is_sample_in = 1'b0;
               state_in     = S_FIN;
               unique case (mode_type'(req_mode))
                  MODE_SAMPLE: begin
                     is_sample_in = 1'b1;
                     hist_we      = 1'b1;
                     u_wp_in      = u_next;
                     iss_in       = 1'b1;
                     term_in      = '0;
                     acc_in       = '0;
                     state_in     = S_MAC;
                  end
                  MODE_WR_B: begin
                     coef_we    = (CNT_W'(req_tap_index) < CNT_W'(MAX_B_TAPS));
                     coef_waddr = CAW'(req_tap_index);
                  end
                  MODE_WR_A: begin
                     coef_we    = (CNT_W'(req_tap_index) < CNT_W'(MAX_A_TAPS));
                     coef_waddr = CAW'(CNT_W'(MAX_B_TAPS) + CNT_W'(req_tap_index));
                  end
                  MODE_CLEAR: begin
                     hist_clr = 1'b1;
                  end
               endcase
            end
         end
         S_MAC: begin
            // The sum is final once the last term has left every pipeline stage.
            if (!iss_ff && !rd_vld_ff && !mul_vld_ff) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            neg_in   = acc_ff[ACC_W-1] ^ a0_ff[COEF_W-1];
            mag_in   = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            a0mag_in = a0_ff[COEF_W-1] ? COEF_W'(-a0_ff) : COEF_W'(a0_ff);
            fact_in  = NOISE_BASE + FACT_W'({noise_ff, 1'b0});
            if (a0_ff == '0) begin
               y_in     = '0;
               stat_in  = STAT_A0_ZERO;
               state_in = S_FIN;
            end else begin
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            pp_lo_in = mag_ff[LO_W-1:0] * fact_ff;
            den_in   = a0mag_ff * NOISE_DEN;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            pp_hi_in = mag_ff[ACC_W-1:LO_W] * fact_ff;
            state_in = S_PREP;
         end
         S_PREP: begin
            // Rounding to nearest: quotient of (2n + d) by 2d.
            num_in   = ((N_W'(pp_lo_ff) + (N_W'(pp_hi_ff) << LO_W)) << 1) + N_W'(den_ff);
            dvs_in   = N_W'(den_ff) << 1;
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_res.done) begin
               if (div_res.ovf || (!neg_ff && (div_res.quot > Q_POS_LIM)) ||
                   (neg_ff && (div_res.quot > Q_NEG_LIM))) begin
                  y_in    = neg_ff ? SAT_NEG : SAT_POS;
                  stat_in = STAT_SAT;
               end else begin
                  y_in    = neg_ff ? SAMPLE_W'(QUOT_W'(0) - div_res.quot)
                                   : SAMPLE_W'(div_res.quot);
                  stat_in = STAT_OK;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (is_sample_ff) begin
                  rsp_y_in      = y_ff;
                  rsp_done_in   = 1'b1;
                  rsp_status_in = stat_ff;
                  hist_we       = 1'b1;
                  hist_waddr    = HAW'(CNT_W'(UD) + CNT_W'(y_next));
                  hist_wdata    = y_ff;
                  y_wp_in       = y_next;
               end else begin
                  rsp_y_in      = '0;
                  rsp_done_in   = 1'b0;
                  rsp_status_in = STAT_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_sample_done = rsp_done_ff;
   assign rsp_status      = rsp_status_ff;

   `ARX_ASSERT_IMP(a_issue_in_mac, clock, reset, iss_ff, state_ff == S_MAC,
      "term issued outside the accumulate phase")
   `ARX_ASSERT_IMP(a_nonsample_zero, clock, reset, rsp_valid_ff && !rsp_done_ff,
      (rsp_y_ff == '0) && (rsp_status_ff == STAT_OK), "non-sample result is not zero")
   `ARX_ASSERT_IMP(a_a0_zero_result, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STAT_A0_ZERO), (rsp_y_ff == '0) && rsp_done_ff,
      "zero leading coefficient gave a non-zero sample")
   `ARX_ASSERT_NEXT(a_div_to_fin, clock, reset, (state_ff == S_DIV) && div_res.done,
      state_ff == S_FIN, "division result not taken")

endmodule

### tb/tb_arx_plant_simulator_top.sv
// Self-checking testbench for the ARX plant simulator top level.
`timescale 1ns / 1ps

class arx_scoreboard;
   logic signed [17:0] b_coef[8];
   logic signed [17:0] a_coef[8];
   logic signed [15:0] u_hist[16];
   logic signed [15:0] y_hist[8];
   logic [3:0] delay_reg, nb_reg, na_reg;
   logic signed [15:0] exp_y[$];
   logic exp_done[$];
   logic [1:0] exp_status[$];
   int mismatches;

   function new();
      foreach (b_coef[i]) b_coef[i] = '0;
      foreach (a_coef[i]) a_coef[i] = '0;
      foreach (u_hist[i]) u_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      delay_reg = 4'd0;
      nb_reg = 4'd1;
      na_reg = 4'd1;
      mismatches = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [3:0] val);
      if (idx == arx_pkg::CSR_INPUT_DELAY) delay_reg = val;
      else if (idx == arx_pkg::CSR_B_TAPS) nb_reg = val;
      else if (idx == arx_pkg::CSR_A_TAPS) na_reg = val;
   endfunction

   // Works out the output of one accepted item and queues it.
   function void note_item(logic [1:0] mode, logic [2:0] tap, logic signed [17:0] coef,
                           logic signed [15:0] u, logic [14:0] noise);
      int k, nb, na;
      longint acc, num, den, q, un, ud;
      logic signed [15:0] y;
      logic [1:0] st;
      logic neg;
      y = '0;
      st = arx_pkg::STAT_OK;
      case (mode)
         arx_pkg::MODE_WR_B: b_coef[tap] = coef;
         arx_pkg::MODE_WR_A: a_coef[tap] = coef;
         arx_pkg::MODE_CLEAR: begin
            foreach (u_hist[i]) u_hist[i] = '0;
            foreach (y_hist[i]) y_hist[i] = '0;
         end
         default: begin
            k = (delay_reg > 8) ? 8 : delay_reg;
            nb = (nb_reg < 1) ? 1 : (nb_reg > 8) ? 8 : nb_reg;
            na = (na_reg < 1) ? 1 : (na_reg > 8) ? 8 : na_reg;
            for (int i = 15; i > 0; i--) u_hist[i] = u_hist[i-1];
            u_hist[0] = u;
            acc = 0;
            for (int i = 0; i < nb; i++) acc += longint'(b_coef[i]) * longint'(u_hist[k+i]);
            for (int j = 1; j < na; j++) acc -= longint'(a_coef[j]) * longint'(y_hist[j-1]);
            if (a_coef[0] == 0) begin
               st = arx_pkg::STAT_A0_ZERO;
            end else begin
               num = acc * (longint'(6520633) + 2 * longint'(noise));
               den = longint'(6553400) * longint'(a_coef[0]);
               neg = (num < 0) != (den < 0);
               un = (num < 0) ? -num : num;
               ud = (den < 0) ? -den : den;
               q = (2 * un + ud) / (2 * ud);
               if (neg) q = -q;
               if (q > 32767) begin
                  y = 16'sh7FFF;
                  st = arx_pkg::STAT_SAT;
               end else if (q < -32768) begin
                  y = 16'sh8000;
                  st = arx_pkg::STAT_SAT;
               end else begin
                  y = q[15:0];
               end
            end
            for (int i = 7; i > 0; i--) y_hist[i] = y_hist[i-1];
            y_hist[0] = y;
         end
      endcase
      exp_y.push_back(y);
      exp_done.push_back(mode == arx_pkg::MODE_SAMPLE);
      exp_status.push_back(st);
   endfunction

   function void check_result(logic signed [15:0] y, logic done, logic [1:0] st);
      if (exp_y.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result transfer: y %0d", y);
         return;
      end
      if (y !== exp_y[0] || done !== exp_done[0] || st !== exp_status[0]) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: expected y %0d done %0b status %0d, ",
                      "got y %0d done %0b status %0d"},
                     exp_y[0], exp_done[0], exp_status[0], y, done, st);
      end
      void'(exp_y.pop_front());
      void'(exp_done.pop_front());
      void'(exp_status.pop_front());
   endfunction
endclass

module tb_arx_plant_simulator_top;
   import arx_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_mode = '0;
   logic [2:0] req_tap_index = '0;
   logic signed [17:0] req_coef_value = '0;
   logic signed [15:0] req_sample_in = '0;
   logic [14:0] req_noise_raw = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_y_out;
   logic rsp_sample_done;
   logic [1:0] rsp_status;
   logic csr_write_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_wdata = '0;

   arx_scoreboard plant_sb;
   int idle_cycles;
   int burst_left;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   arx_plant_simulator_top u_top (.*);

   // Receiver stall pattern: long ready stretches, short and occasional long stalls.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 8) rsp_ready <= 1'b0;
      else if ($urandom_range(0, 99) < 60) rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         plant_sb.check_result(rsp_y_out, rsp_sample_done, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_arx_plant_simulator_top failed");
         $finish;
      end
   end

   // Valid stays high from one transfer to the next within a burst; it drops only
   // for a gap or a drain.
   task automatic send_item(logic [1:0] mode, logic [2:0] tap, logic signed [17:0] coef,
                            logic signed [15:0] u, logic [14:0] noise);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_tap_index <= tap;
      req_coef_value <= coef;
      req_sample_in <= u;
      req_noise_raw <= noise;
      do @(posedge clock); while (!req_ready);
      plant_sb.note_item(mode, tap, coef, u, noise);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (plant_sb.exp_y.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [3:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      plant_sb.set_reg(idx, val);
   endtask

   task automatic rand_sample();
      send_item(MODE_SAMPLE, 3'($urandom), 18'($urandom), 16'($urandom),
                15'($urandom_range(0, 32767)));
   endtask

   // A0 kept near one so outputs stay mostly in range; other taps small.
   task automatic load_stable_coefs();
      send_item(MODE_WR_A, 3'd0, 18'sd16384 + 18'($urandom_range(0, 8000)), '0, '0);
      for (int i = 1; i < 8; i++)
         send_item(MODE_WR_A, 3'(i), 18'(int'($urandom_range(0, 6000)) - 3000), '0, '0);
      for (int i = 0; i < 8; i++)
         send_item(MODE_WR_B, 3'(i), 18'(int'($urandom_range(0, 12000)) - 6000), '0, '0);
   endtask

   initial begin
      logic [3:0] settings[6][3];
      plant_sb = new();
      burst_left = 0;
      settings = '{'{4'd0, 4'd1, 4'd1}, '{4'd8, 4'd8, 4'd8}, '{4'd15, 4'd0, 4'd0},
                   '{4'd3, 4'd4, 4'd2}, '{4'd1, 4'd15, 4'd15}, '{4'd5, 4'd2, 4'd6}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: A0 zero, coefficient extremes, saturation, clear, noise extremes.
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sh7FFF, 15'd0);
      send_item(MODE_WR_B, 3'd0, 18'sh1FFFF, '0, '0);
      send_item(MODE_WR_A, 3'd0, 18'sd16384, '0, '0);
      send_item(MODE_SAMPLE, 3'd7, '0, 16'sh7FFF, 15'd32767);
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sh8000, 15'd0);
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sd256, 15'd16383);
      send_item(MODE_WR_B, 3'd1, 18'sh20000, '0, '0);
      send_item(MODE_WR_A, 3'd1, 18'sh20000, '0, '0);
      send_item(MODE_WR_A, 3'd0, 18'sh20000, 16'sh7FFF, 15'h7FFF);
      send_item(MODE_SAMPLE, 3'd0, 18'sh3FFFF, -16'sd1, 15'd1);
      send_item(MODE_WR_A, 3'd0, -18'sd1, '0, '0);
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sh7FFF, 15'd32766);
      send_item(MODE_CLEAR, 3'd7, 18'sh1FFFF, 16'sh7FFF, 15'h7FFF);
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sd0, 15'd0);
      send_item(MODE_WR_A, 3'd0, '0, '0, '0);
      send_item(MODE_SAMPLE, 3'd0, '0, 16'sd100, 15'd100);

      // The sender holds off here until every result is back.
      drain();
      for (int p = 0; p < 6; p++) begin
         drain();
         for (int r = 0; r < 3; r++) write_reg(2'(r), settings[p][r]);
         write_reg(2'd3, 4'($urandom));
         csr_write_en <= 1'b0;
         if (p != 2) load_stable_coefs();
         for (int n = 0; n < 68; n++) begin
            case ($urandom_range(0, 19))
               0: send_item(MODE_CLEAR, 3'($urandom), 18'($urandom), 16'($urandom),
                            15'($urandom));
               1: send_item(MODE_WR_B, 3'($urandom), 18'($urandom), '0, '0);
               2: send_item(MODE_WR_A, 3'($urandom_range(1, 7)), 18'($urandom), '0, '0);
               default: rand_sample();
            endcase
         end
      end

      drain();
      if (plant_sb.mismatches == 0 && plant_sb.exp_y.size() == 0)
         $display("tb_arx_plant_simulator_top passed");
      else
         $display("tb_arx_plant_simulator_top failed");
      $finish;
   end
endmodule

### files.f
+incdir+hw/rtl
hw/rtl/arx_pkg.sv
hw/rtl/arx_div.sv
hw/rtl/arx_plant_simulator_top.sv
tb/tb_arx_plant_simulator_top.sv
